@@ sv/mrlp_pkg.sv @@
// Shared types and constants for the modem response line parser.
// Used by the front, command queue, back and checker files; depends on nothing.
`default_nettype none

package mrlp_pkg;

    // Command passed from front to back through the queue
    typedef enum logic {
        CMD_PROMPT = 1'b0,
        CMD_LINE   = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      busy;
    } cmd_t;

    // Result kinds on the output channel
    typedef enum logic [1:0] {
        EV_PROMPT = 2'd0,
        EV_LINE   = 2'd1,
        EV_NUMBER = 2'd2
    } event_kind_t;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;

    localparam logic [15:0] PAT_OK    = "OK";
    localparam logic [39:0] PAT_ERROR = "ERROR";

    localparam int PREFIX_LEN = 8;

    // Caller identification prefix: +CLIP: followed by a quote
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h2B;
            3'd1: ch = 8'h43;
            3'd2: ch = 8'h4C;
            3'd3: ch = 8'h49;
            3'd4: ch = 8'h50;
            3'd5: ch = 8'h3A;
            3'd6: ch = 8'h20;
            3'd7: ch = 8'h22;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CHAR_SPACE) || (ch == CHAR_CR) || (ch == CHAR_NL);
    endfunction

endpackage

`default_nettype wire

@@ sv/modem_response_line_parser.sv @@
// Top level of the modem response line parser: front, command queue and back.
// Uses mrlp_pkg, mrlp_front, mrlp_cmd_fifo and mrlp_back.
//
// Bytes from the modem UART enter on the input channel and are stored in a
// line store of LINE_CAPACITY bytes. An ordinary byte never causes an input stall.
// A space after '>' yields one prompt result; the front keeps taking bytes
// while the result waits, until the command queue is full. A newline starts
// a line-end job in the back: the back scans the stored line through the
// single read port of the line store, one byte a cycle, and then loads the
// line-end result; for a caller identification line it then emits up to
// NUMBER_MAX number characters, each with one store read and one output
// load. Input is stalled from the newline until that job ends, and an output
// stall lengthens that hold. Every result carries last on the final result
// caused by one input byte.
`default_nettype none

module modem_response_line_parser
    import mrlp_pkg::*;
#(
    parameter int LINE_CAPACITY = 99,
    parameter int NUMBER_MAX = 19
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       sms_busy,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      event_kind,
    output logic            ok_found,
    output logic            error_found,
    output logic            clip_found,
    output logic [7:0]      number_char,
    output logic            last
);

    localparam int IW = $clog2(LINE_CAPACITY);
    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam int NW = $clog2(NUMBER_MAX + 1);

    logic          q_push;
    cmd_t          q_wdata;
    logic          q_full;
    logic          q_valid;
    cmd_t          q_rdata;
    logic          q_pop;
    logic          line_done;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [CW-1:0] line_len;

    mrlp_front #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .IW            (IW),
        .CW            (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .sms_busy  (sms_busy),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .q_full    (q_full),
        .line_done (line_done),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .line_len  (line_len)
    );

    mrlp_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .valid (q_valid),
        .rdata (q_rdata),
        .pop   (q_pop)
    );

    mrlp_back #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .NUMBER_MAX    (NUMBER_MAX),
        .IW            (IW),
        .CW            (CW),
        .NW            (NW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .line_len    (line_len),
        .q_valid     (q_valid),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .line_done   (line_done),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .ok_found    (ok_found),
        .error_found (error_found),
        .clip_found  (clip_found),
        .number_char (number_char),
        .last        (last)
    );

endmodule

`default_nettype wire

@@ sv/mrlp_front.sv @@
// Input side of the line parser: takes bytes, tracks the fill count, spots
// prompts and line ends and queues a command for the back. Uses mrlp_pkg.
`default_nettype none

module mrlp_front
    import mrlp_pkg::*;
#(
    parameter int LINE_CAPACITY = 99,
    parameter int IW = $clog2(LINE_CAPACITY),
    parameter int CW = $clog2(LINE_CAPACITY + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          sms_busy,
    output logic               q_push,
    output cmd_t               q_data,
    input  wire logic          q_full,
    input  wire logic          line_done,
    output logic               wr_en,
    output logic [IW-1:0]      wr_addr,
    output logic [7:0]         wr_data,
    output logic [CW-1:0]      line_len
);

    logic [CW-1:0] fill_reg, fill_next;
    logic [7:0]    prev_reg;
    logic [CW-1:0] len_reg;
    logic          line_pend_reg, line_pend_next;

    logic          accept;
    logic          store_full;
    logic [CW-1:0] new_fill;
    logic          is_prompt;
    logic          is_nl;

    // Hold input while the command queue is full or the back is still on the last line end
    assign in_stall = q_full || line_pend_reg;
    assign accept   = in_valid && !in_stall;

    assign store_full = (fill_reg == CW'(LINE_CAPACITY));
    assign new_fill   = store_full ? CW'(1) : fill_reg + CW'(1);
    assign is_prompt  = (rx_byte == CHAR_SPACE) && (new_fill >= CW'(2)) &&
                        (prev_reg == CHAR_GT);
    assign is_nl      = (rx_byte == CHAR_NL);

    assign wr_en    = accept;
    assign wr_addr  = store_full ? '0 : fill_reg[IW-1:0];
    assign wr_data  = rx_byte;
    assign line_len = len_reg;

    assign q_push      = accept && (is_prompt || is_nl);
    assign q_data.kind = is_prompt ? CMD_PROMPT : CMD_LINE;
    assign q_data.busy = sms_busy;

    always_comb
    begin
        fill_next      = fill_reg;
        line_pend_next = line_pend_reg;
        if (line_done)
        begin
            line_pend_next = 1'b0;
        end
        if (accept)
        begin
            if (is_prompt || is_nl)
            begin
                fill_next = '0;
            end
            else
            begin
                fill_next = new_fill;
            end
            if (is_nl)
            begin
                line_pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            line_pend_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            line_pend_reg <= line_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_reg <= rx_byte;
            if (is_nl)
            begin
                len_reg <= new_fill;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/mrlp_cmd_fifo.sv @@
// Two-entry command queue between the front and the back of the line parser.
// Uses cmd_t from mrlp_pkg.
`default_nettype none

module mrlp_cmd_fifo
    import mrlp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t wdata,
    output logic      full,
    output logic      valid,
    output cmd_t      rdata,
    input  wire logic pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ sv/mrlp_back.sv @@
// Result side of the line parser: holds the line store, scans a finished
// line one byte a cycle, then emits the line-end and caller number results.
// Uses mrlp_pkg.
`default_nettype none

module mrlp_back
    import mrlp_pkg::*;
#(
    parameter int LINE_CAPACITY = 99,
    parameter int NUMBER_MAX = 19,
    parameter int IW = $clog2(LINE_CAPACITY),
    parameter int CW = $clog2(LINE_CAPACITY + 1),
    parameter int NW = $clog2(NUMBER_MAX + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [CW-1:0] line_len,
    input  wire logic          q_valid,
    input  wire cmd_t          q_data,
    output logic               q_pop,
    output logic               line_done,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         event_kind,
    output logic               ok_found,
    output logic               error_found,
    output logic               clip_found,
    output logic [7:0]         number_char,
    output logic               last
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_CALC   = 6'b000100,
        ST_REPORT = 6'b001000,
        ST_NUM_RD = 6'b010000,
        ST_NUM_WR = 6'b100000
    } state_t;

    logic [7:0] mem [LINE_CAPACITY];

    state_t        state_reg, state_next;
    logic          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0] rd_addr_reg, rd_addr_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic [7:0]    rd_data_reg;
    logic [31:0]   win_reg, win_next;
    logic          zero_reg, zero_next;
    logic          ok_reg, ok_next;
    logic          err_reg, err_next;
    logic          clip_reg, clip_next;
    logic [CW-1:0] trim_reg, trim_next;
    logic          quote_seen_reg, quote_seen_next;
    logic [CW-1:0] quote_reg, quote_next;
    logic          busy_reg, busy_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] num_addr_reg, num_addr_next;

    logic [1:0]    ev_reg, ev_next;
    logic          okf_reg, okf_next;
    logic          errf_reg, errf_next;
    logic          clipf_reg, clipf_next;
    logic [7:0]    ch_reg, ch_next;
    logic          last_reg, last_next;

    logic          rd_en;
    logic [IW-1:0] rd_idx;
    logic          out_free;
    logic          issue;
    logic [7:0]    d;
    logic          clip_line;
    logic [CW-1:0] end_pos;
    logic [CW-1:0] diff;
    logic          num_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign issue    = (rd_addr_reg < line_len);
    assign d        = rd_data_reg;
    assign num_last = (NW'(cnt_reg + NW'(1)) == n_reg);

    assign clip_line = clip_reg && (trim_reg >= CW'(PREFIX_LEN));
    assign end_pos   = (quote_seen_reg && (quote_reg < trim_reg)) ? quote_reg : trim_reg;
    assign diff      = end_pos - CW'(PREFIX_LEN);

    always_comb
    begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        rd_addr_next    = rd_addr_reg;
        pend_idx_next   = pend_idx_reg;
        win_next        = win_reg;
        zero_next       = zero_reg;
        ok_next         = ok_reg;
        err_next        = err_reg;
        clip_next       = clip_reg;
        trim_next       = trim_reg;
        quote_seen_next = quote_seen_reg;
        quote_next      = quote_reg;
        busy_next       = busy_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        num_addr_next   = num_addr_reg;
        ev_next         = ev_reg;
        okf_next        = okf_reg;
        errf_next       = errf_reg;
        clipf_next      = clipf_reg;
        ch_next         = ch_reg;
        last_next       = last_reg;
        rd_en           = 1'b0;
        rd_idx          = num_addr_reg;
        q_pop           = 1'b0;
        line_done       = 1'b0;

        // Drop the shown result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.kind == CMD_PROMPT)
                    begin
                        if (out_free)
                        begin
                            q_pop          = 1'b1;
                            out_valid_next = 1'b1;
                            ev_next        = EV_PROMPT;
                            okf_next       = 1'b0;
                            errf_next      = 1'b0;
                            clipf_next     = 1'b0;
                            ch_next        = 8'h00;
                            last_next      = 1'b1;
                        end
                    end
                    else
                    begin
                        q_pop           = 1'b1;
                        busy_next       = q_data.busy;
                        rd_addr_next    = '0;
                        pend_next       = 1'b0;
                        win_next        = '0;
                        zero_next       = 1'b0;
                        ok_next         = 1'b0;
                        err_next        = 1'b0;
                        clip_next       = 1'b1;
                        trim_next       = '0;
                        quote_seen_next = 1'b0;
                        quote_next      = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                rd_idx = rd_addr_reg[IW-1:0];
                if (issue)
                begin
                    rd_en         = 1'b1;
                    rd_addr_next  = rd_addr_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_addr_reg[IW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // Judge the line only up to its first zero byte
                if (pend_reg && !zero_reg)
                begin
                    if (d == 8'h00)
                    begin
                        zero_next = 1'b1;
                    end
                    else
                    begin
                        win_next = {win_reg[23:0], d};
                        if ({win_reg[7:0], d} == PAT_OK)
                        begin
                            ok_next = 1'b1;
                        end
                        if ({win_reg, d} == PAT_ERROR)
                        begin
                            err_next = 1'b1;
                        end
                        if (!is_blank(d))
                        begin
                            trim_next = CW'(pend_idx_reg) + CW'(1);
                        end
                        if (pend_idx_reg < IW'(PREFIX_LEN))
                        begin
                            if (d != prefix_char(pend_idx_reg[2:0]))
                            begin
                                clip_next = 1'b0;
                            end
                        end
                        else if ((d == CHAR_QUOTE) && !quote_seen_reg)
                        begin
                            quote_seen_next = 1'b1;
                            quote_next      = CW'(pend_idx_reg);
                        end
                    end
                end

                if (!issue && !pend_reg)
                begin
                    state_next = ST_CALC;
                end
            end

            ST_CALC:
            begin
                clip_next = clip_line;
                n_next    = '0;
                if (clip_line && !busy_reg && (end_pos > CW'(PREFIX_LEN)))
                begin
                    if ({{NW{1'b0}}, diff} > (CW + NW)'(NUMBER_MAX))
                    begin
                        n_next = NW'(NUMBER_MAX);
                    end
                    else
                    begin
                        n_next = NW'(diff);
                    end
                end
                state_next = ST_REPORT;
            end

            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ev_next        = EV_LINE;
                    okf_next       = ok_reg;
                    errf_next      = err_reg;
                    clipf_next     = clip_reg;
                    ch_next        = 8'h00;
                    last_next      = (n_reg == '0);
                    cnt_next       = '0;
                    num_addr_next  = IW'(PREFIX_LEN);
                    if (n_reg == '0)
                    begin
                        line_done  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_NUM_RD;
                    end
                end
            end

            ST_NUM_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_NUM_WR;
            end

            ST_NUM_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ev_next        = EV_NUMBER;
                    okf_next       = 1'b0;
                    errf_next      = 1'b0;
                    clipf_next     = 1'b1;
                    ch_next        = rd_data_reg;
                    last_next      = num_last;
                    cnt_next       = cnt_reg + NW'(1);
                    num_addr_next  = num_addr_reg + IW'(1);
                    if (num_last)
                    begin
                        line_done  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_NUM_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        pend_idx_reg   <= pend_idx_next;
        win_reg        <= win_next;
        zero_reg       <= zero_next;
        ok_reg         <= ok_next;
        err_reg        <= err_next;
        clip_reg       <= clip_next;
        trim_reg       <= trim_next;
        quote_seen_reg <= quote_seen_next;
        quote_reg      <= quote_next;
        busy_reg       <= busy_next;
        n_reg          <= n_next;
        cnt_reg        <= cnt_next;
        num_addr_reg   <= num_addr_next;
        ev_reg         <= ev_next;
        okf_reg        <= okf_next;
        errf_reg       <= errf_next;
        clipf_reg      <= clipf_next;
        ch_reg         <= ch_next;
        last_reg       <= last_next;
    end

    // Line store: one write port from the front, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = ev_reg;
    assign ok_found    = okf_reg;
    assign error_found = errf_reg;
    assign clip_found  = clipf_reg;
    assign number_char = ch_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

@@ sv/mrlp_checker.sv @@
// Port-level checker for the modem response line parser, bound to the top.
// Uses event codes from mrlp_pkg.
`default_nettype none

module mrlp_checker
    import mrlp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] rx_byte,
    input wire logic       sms_busy,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] event_kind,
    input wire logic       ok_found,
    input wire logic       error_found,
    input wire logic       clip_found,
    input wire logic [7:0] number_char,
    input wire logic       last
);

    // A stalled input item stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(rx_byte) && $stable(sms_busy))
        else $error("stalled input item changed");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_kind) &&
        $stable(number_char) && $stable(last))
        else $error("stalled result changed");

    // A number result carries the caller identification flag and no other flag
    a_number_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_NUMBER) |->
        clip_found && !ok_found && !error_found)
        else $error("number result with wrong flags");

    // A prompt is a single result with no flags
    a_prompt_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_PROMPT) |->
        last && !ok_found && !error_found && !clip_found && (number_char == 8'h00))
        else $error("prompt result malformed");

    // A line-end result carries no character
    a_line_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_LINE) |-> (number_char == 8'h00))
        else $error("line-end result carries a character");

endmodule

bind modem_response_line_parser mrlp_checker u_checker (.*);

`default_nettype wire

@@ tb/mrlp_event_checker.sv @@
// Checker for the modem response line parser: watches both channels, predicts
// the results of every accepted byte and compares them in order.
// Depends on mrlp_pkg for the result kinds and character codes.
module mrlp_event_checker
    import mrlp_pkg::*;
#(
    parameter int LINE_CAPACITY = 99,
    parameter int NUMBER_MAX = 19
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       sms_busy,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [1:0] event_kind,
    input  wire logic       ok_found,
    input  wire logic       error_found,
    input  wire logic       clip_found,
    input  wire logic [7:0] number_char,
    input  wire logic       last,
    output int              fail_count,
    output int              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] OK_TEXT    = "OK";
    localparam logic [39:0] ERROR_TEXT = "ERROR";
    localparam logic [63:0] CLIP_TEXT  = "+CLIP: \"";

    typedef struct {
        event_kind_t kind;
        logic        ok;
        logic        err;
        logic        clip;
        logic [7:0]  ch;
        logic        last;
    } line_event_t;

    line_event_t expected_events[$];
    line_event_t head_event;
    logic [7:0]  line_mem [LINE_CAPACITY];
    int          line_fill;

    // Text is right-aligned in the vector, first character in the top byte.
    function automatic bit line_holds(input int len, input logic [63:0] text,
                                      input int plen);
        int s;
        int k;
        bit hit;
        for (s = 0; s + plen <= len; s++)
        begin
            hit = 1'b1;
            for (k = 0; k < plen; k++)
            begin
                if (line_mem[s + k] != text[8 * (plen - 1 - k) +: 8])
                    hit = 1'b0;
            end
            if (hit)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_event(input event_kind_t kind, input logic ok,
                              input logic err, input logic clip,
                              input logic [7:0] ch, input logic fin);
        line_event_t ev;
        ev.kind = kind;
        ev.ok   = ok;
        ev.err  = err;
        ev.clip = clip;
        ev.ch   = ch;
        ev.last = fin;
        expected_events.push_back(ev);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic busy);
        int len;
        int n;
        int i;
        bit ok;
        bit err;
        bit clip;
        // A full line starts over with this byte
        if (line_fill >= LINE_CAPACITY)
            line_fill = 0;
        line_mem[line_fill] = b;
        line_fill++;
        if (b == CHAR_SPACE && line_fill >= 2 && line_mem[line_fill - 2] == CHAR_GT)
        begin
            line_fill = 0;
            push_event(EV_PROMPT, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
            return;
        end
        if (b == CHAR_NL)
        begin
            // Judge up to the first zero byte, trailing blanks dropped
            len = 0;
            while (len < line_fill && line_mem[len] != 8'h00)
                len++;
            while (len > 0 && (line_mem[len - 1] == CHAR_SPACE ||
                               line_mem[len - 1] == CHAR_CR ||
                               line_mem[len - 1] == CHAR_NL))
                len--;
            ok   = line_holds(len, OK_TEXT, 2);
            err  = line_holds(len, ERROR_TEXT, 5);
            clip = (len >= 8) && line_holds(8, CLIP_TEXT, 8);
            n = 0;
            if (clip && !busy)
            begin
                while (n < NUMBER_MAX && 8 + n < len && line_mem[8 + n] != CHAR_QUOTE)
                    n++;
            end
            push_event(EV_LINE, ok, err, clip, 8'h00, n == 0);
            for (i = 0; i < n; i++)
                push_event(EV_NUMBER, 1'b0, 1'b0, 1'b1, line_mem[8 + i], i + 1 == n);
            line_fill = 0;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            line_fill = 0;
            expected_events.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_byte(rx_byte, sms_busy);
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: result with nothing expected: kind=%0d ok=%0b err=%0b",
                             $time, event_kind, ok_found, error_found,
                             " clip=%0b char=%02h last=%0b",
                             clip_found, number_char, last);
                    fail_count++;
                end
                else
                begin
                    head_event = expected_events.pop_front();
                    if (event_kind !== head_event.kind || ok_found !== head_event.ok ||
                        error_found !== head_event.err || clip_found !== head_event.clip ||
                        number_char !== head_event.ch || last !== head_event.last)
                    begin
                        $display("%0t: mismatch: expected kind=%0d ok=%0b err=%0b clip=%0b",
                                 $time, head_event.kind, head_event.ok, head_event.err,
                                 head_event.clip, " char=%02h last=%0b",
                                 head_event.ch, head_event.last);
                        $display("%0t:           actual kind=%0d ok=%0b err=%0b clip=%0b",
                                 $time, event_kind, ok_found, error_found, clip_found,
                                 " char=%02h last=%0b", number_char, last);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_events.size();
        end
    end

endmodule

@@ tb/tb_modem_response_line_parser.sv @@
// Testbench top for the modem response line parser: clock, reset, byte
// stimulus, output stall and the verdict.
// Depends on mrlp_pkg, modem_response_line_parser and mrlp_event_checker.
module tb_modem_response_line_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import mrlp_pkg::*;

    localparam int PHASE_ITEMS  = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       sms_busy = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] event_kind;
    logic       ok_found;
    logic       error_found;
    logic       clip_found;
    logic [7:0] number_char;
    logic       last;
    int         fail_count;
    int         pending_count;

    int         idle_pct = 0;
    int         stall_pct = 0;
    logic       hold_req = 1'b0;
    logic       hold_done = 1'b0;
    int         bytes_sent = 0;
    logic [7:0] line_q[$];

    modem_response_line_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .sms_busy    (sms_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .ok_found    (ok_found),
        .error_found (error_found),
        .clip_found  (clip_found),
        .number_char (number_char),
        .last        (last)
    );

    mrlp_event_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .sms_busy      (sms_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .ok_found      (ok_found),
        .error_found   (error_found),
        .clip_found    (clip_found),
        .number_char   (number_char),
        .last          (last),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random stall, or one long hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done <= 1'b1;
                out_stall <= ($urandom_range(99) < stall_pct);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic busy);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        sms_busy <= busy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line(input logic busy);
        while (line_q.size() != 0)
            send_byte(line_q.pop_front(), busy);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_count == 0);
    endtask

    task automatic add_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            line_q.push_back(text[i]);
    endtask

    // Printable, no spaces, so no prompt can form inside
    task automatic add_junk(input int count);
        repeat (count) line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
    endtask

    task automatic add_blanks();
        repeat ($urandom_range(0, 3))
            line_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_CR);
    endtask

    task automatic make_random_line();
        int kind;
        int nlen;
        kind = $urandom_range(0, 19);
        if (kind <= 3)
        begin
            add_junk($urandom_range(0, 4));
            add_text("OK");
            add_blanks();
            line_q.push_back(CHAR_NL);
        end
        else if (kind <= 5)
        begin
            add_junk($urandom_range(0, 3));
            add_text("ERROR");
            add_junk($urandom_range(0, 2));
            add_blanks();
            line_q.push_back(CHAR_NL);
        end
        else if (kind <= 10)
        begin
            add_text("+CLIP: \"");
            // Break the prefix now and then
            if ($urandom_range(5) == 0)
                line_q[$urandom_range(7)] = 8'($urandom_range(8'h20, 8'h7E));
            nlen = $urandom_range(0, 24);
            repeat (nlen)
            begin
                case ($urandom_range(9))
                    0: line_q.push_back("+");
                    1: line_q.push_back(CHAR_SPACE);
                    default: line_q.push_back(8'(8'h30 + $urandom_range(9)));
                endcase
            end
            if ($urandom_range(2) != 0)
                add_text("\",145,\"\",0,\"\",0");
            add_blanks();
            line_q.push_back(CHAR_NL);
        end
        else if (kind <= 12)
        begin
            add_junk($urandom_range(0, 5));
            add_text("> ");
        end
        else if (kind <= 14)
        begin
            repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(1))
                line_q.push_back(CHAR_NL);
        end
        else if (kind <= 16)
        begin
            add_junk($urandom_range(0, 3));
            if ($urandom_range(1))
            begin
                line_q.push_back(8'h00);
                add_text("OK");
            end
            else
            begin
                add_text("ERROR");
                line_q.push_back(8'h00);
                add_junk($urandom_range(0, 3));
            end
            line_q.push_back(CHAR_NL);
        end
        else if (kind <= 18)
        begin
            add_junk($urandom_range(1, 8));
            add_blanks();
            line_q.push_back(CHAR_NL);
        end
        else
        begin
            // Overrun the line store
            if ($urandom_range(1))
            begin
                add_junk(98);
                add_text("> ");
            end
            else
            begin
                add_junk($urandom_range(99, 120));
                line_q.push_back(CHAR_NL);
            end
        end
    endtask

    initial
    begin
        int phase_idx;
        int phase_start;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        add_text("> ");
        send_line(1'b0);
        add_text("OK");
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_NL);
        send_line(1'b0);
        line_q.push_back(8'hFF);
        add_text("ERROR");
        line_q.push_back(8'h00);
        add_text("OK");
        line_q.push_back(CHAR_NL);
        send_line(1'b1);
        add_text("+CLIP: \"12\" ");
        line_q.push_back(CHAR_NL);
        send_line(1'b0);
        pause_until_drained();

        // Hold the output while bytes keep coming, so the input backs up
        @(negedge clk);
        hold_req <= 1'b1;
        repeat (6) add_text("> ");
        send_line(1'b0);
        add_text("+CLIP: \"0123456789012345678901\",129");
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_NL);
        add_junk(98);
        add_text("> ");
        add_text("OK");
        line_q.push_back(CHAR_NL);
        send_line(1'b0);
        wait (hold_done);
        pause_until_drained();

        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            case (phase_idx)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS)
            begin
                make_random_line();
                send_line($urandom_range(3) == 0);
            end
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
